[rtl/sdsad_pkg.sv]
package sdsad_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_NUM_DISPARITIES = 2'd2;

    localparam logic [10:0] RESET_IMAGE_WIDTH     = 11'd640;
    localparam logic [11:0] RESET_IMAGE_HEIGHT    = 12'd480;
    localparam logic [6:0]  RESET_NUM_DISPARITIES = 7'd64;

    typedef struct packed {
        logic [7:0] left_pixel;
        logic [7:0] right_pixel;
        logic       frame_start;
    } t_pixel;

    typedef struct packed {
        logic [11:0] row;
        logic [9:0]  col;
        logic [5:0]  disparity;
        logic        last_of_frame;
    } t_result;

endpackage

[rtl/sdsad_chan.sv]
interface sdsad_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/sdsad_ram.sv]
module sdsad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/stereo_disparity_sad_unit.sv]
// Streaming SAD block-matching stereo unit. Rectified left/right grey pixel pairs enter in
// raster order, one beat per clock, and for every window center whose full WINDOW x WINDOW
// window lies inside the image the unit delivers one beat with the center's row and column
// and the horizontal shift (0 up to num_disparities-1, capped where the right window would
// leave the row) with the least sum of absolute differences; the smallest shift wins ties.
// Border centers deliver nothing. The unit sustains one pixel per clock when not stalled.
// The previous WINDOW-1 rows of both images live in one line memory (one word per column),
// read when a pixel is accepted and written back from stage 0 as the pipeline advances,
// with forwarding when the same column follows. Per shift lane a column SAD is formed once
// per column and kept over the last WINDOW columns, so each window SAD is a sum of WINDOW
// column sums; a registered minimum tree then picks the best shift. A stall on the result
// side holds the whole pipeline. The user must write configuration only while the unit is
// idle; the unit does not enforce this. Out-of-range values are clamped.
module stereo_disparity_sad_unit #(
    parameter int WINDOW    = 5,
    parameter int MAX_SHIFT = 64,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sdsad_chan.sink              i_px,
    sdsad_chan.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [11:0]          i_cfg_data
);
    localparam int HALF = WINDOW / 2;
    localparam int LR   = WINDOW - 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int XW   = ($clog2(MAX_WIDTH) + 2 > 12) ? $clog2(MAX_WIDTH) + 2 : 12;
    localparam int RAMW = 16 * LR;
    localparam int LV   = (MAX_SHIFT > 1) ? $clog2(MAX_SHIFT) : 0;
    localparam int P    = 1 << LV;
    localparam int DW   = (LV > 0) ? LV : 1;
    localparam int CSW  = $clog2(WINDOW * 255 + 1);
    localparam int SW   = $clog2(WINDOW * WINDOW * 255 + 1);
    localparam int NS   = 4 + LV;

    // Configuration registers.
    logic [10:0] r_cfg_w;
    logic [11:0] r_cfg_h;
    logic [6:0]  r_cfg_nd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= sdsad_pkg::RESET_IMAGE_WIDTH;
            r_cfg_h  <= sdsad_pkg::RESET_IMAGE_HEIGHT;
            r_cfg_nd <= sdsad_pkg::RESET_NUM_DISPARITIES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdsad_pkg::REG_IMAGE_WIDTH:     r_cfg_w  <= i_cfg_data[10:0];
                sdsad_pkg::REG_IMAGE_HEIGHT:    r_cfg_h  <= i_cfg_data;
                sdsad_pkg::REG_NUM_DISPARITIES: r_cfg_nd <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the result register is free or being drained.
    logic adv, acc;
    logic r_out_valid;
    sdsad_pkg::t_result r_out;

    assign adv        = !r_out_valid || o_res.ready;
    assign acc        = i_px.valid && adv;
    assign i_px.ready = adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Raster position of the incoming pixel.
    logic [XW-1:0] r_col;
    logic [11:0]   r_row;
    logic [XW-1:0] wr, wc, c0, c1, nc, dm_a, dm_b;
    logic [12:0]   r0, r1, r2, nr;
    logic [11:0]   hc;
    logic [8:0]    nd9, ndc;
    logic          s0_emit, s0_last;
    logic [DW-1:0] s0_dmax;

    always_comb begin
        wr  = XW'(r_cfg_w);
        if (wr < XW'(WINDOW)) begin
            wc = XW'(WINDOW);
        end else if (wr > XW'(MAX_WIDTH)) begin
            wc = XW'(MAX_WIDTH);
        end else begin
            wc = wr;
        end
        hc  = (r_cfg_h < 12'(WINDOW)) ? 12'(WINDOW) : r_cfg_h;
        nd9 = 9'(r_cfg_nd);
        if (nd9 < 9'd1) begin
            ndc = 9'd1;
        end else if (nd9 > 9'(MAX_SHIFT)) begin
            ndc = 9'(MAX_SHIFT);
        end else begin
            ndc = nd9;
        end

        c0 = i_px.data.frame_start ? '0 : r_col;
        r0 = i_px.data.frame_start ? '0 : {1'b0, r_row};
        if (c0 >= wc) begin
            c1 = '0;
            r1 = r0 + 13'd1;
        end else begin
            c1 = c0;
            r1 = r0;
        end
        r2 = (r1 >= {1'b0, hc}) ? '0 : r1;

        nc = c1 + XW'(1);
        nr = r2;
        if (nc >= wc) begin
            nc = '0;
            nr = r2 + 13'd1;
            if (nr >= {1'b0, hc}) begin
                nr = '0;
            end
        end

        s0_emit = (r2 >= 13'(LR)) && (c1 >= XW'(LR));
        s0_last = (r2 == {1'b0, hc} - 13'd1) && (c1 == wc - XW'(1));
        dm_a    = c1 - XW'(LR);
        dm_b    = XW'(ndc - 9'd1);
        s0_dmax = (dm_a < dm_b) ? dm_a[DW-1:0] : dm_b[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= nc;
            r_row <= nr[11:0];
        end
    end

    // Pipeline bookkeeping: stage 0 holds the line memory output, 1 the new columns,
    // 2 the column sums, 3 + l the minimum tree level l.
    logic          r_v     [NS];
    logic [11:0]   r_mrow  [NS];
    logic [CW-1:0] r_mcol  [NS];
    logic          r_memit [NS];
    logic          r_mlast [NS];
    logic [DW-1:0] r_mdmax [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_v[s] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v[0] <= acc;
            for (int s = 1; s < NS; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_out_valid <= r_v[NS-1] && r_memit[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mrow[0]  <= r2[11:0];
            r_mcol[0]  <= c1[CW-1:0];
            r_memit[0] <= s0_emit;
            r_mlast[0] <= s0_last;
            r_mdmax[0] <= s0_dmax;
            for (int s = 1; s < NS; s++) begin
                r_mrow[s]  <= r_mrow[s-1];
                r_mcol[s]  <= r_mcol[s-1];
                r_memit[s] <= r_memit[s-1];
                r_mlast[s] <= r_mlast[s-1];
                r_mdmax[s] <= r_mdmax[s-1];
            end
        end
    end

    // Line memory: per column, WINDOW-1 rows of the left image, then of the right image.
    logic [7:0]      r_lp, r_rp;
    logic            r_fwd;
    logic [RAMW-1:0] r_wlast, ram_rdata, line, wd;
    logic            ram_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (adv) begin
            r_fwd <= acc && r_v[0] && (c1[CW-1:0] == r_mcol[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_lp <= i_px.data.left_pixel;
            r_rp <= i_px.data.right_pixel;
        end
        if (ram_we) begin
            r_wlast <= wd;
        end
    end

    assign ram_we = r_v[0] && adv;
    assign line   = r_fwd ? r_wlast : ram_rdata;

    always_comb begin
        for (int k = 0; k < LR - 1; k++) begin
            wd[8*k +: 8]      = line[8*(k+1) +: 8];
            wd[8*(LR+k) +: 8] = line[8*(LR+k+1) +: 8];
        end
        wd[8*(LR-1) +: 8]   = r_lp;
        wd[8*(2*LR-1) +: 8] = r_rp;
    end

    sdsad_ram #(
        .WIDTH (RAMW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_mcol[0]),
        .i_wdata (wd),
        .i_re    (acc),
        .i_raddr (c1[CW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Newest left column and the right column history, newest at index 0.
    logic [7:0] r_lc [WINDOW];
    logic [7:0] r_rh [MAX_SHIFT][WINDOW];

    always_ff @(posedge i_clk) begin
        if (r_v[0] && adv) begin
            for (int k = 0; k < LR; k++) begin
                r_lc[k]    <= line[8*k +: 8];
                r_rh[0][k] <= line[8*(LR+k) +: 8];
            end
            r_lc[LR]    <= r_lp;
            r_rh[0][LR] <= r_rp;
            for (int i = 1; i < MAX_SHIFT; i++) begin
                r_rh[i] <= r_rh[i-1];
            end
        end
    end

    // Column sums per shift lane, kept over the last WINDOW columns.
    logic [CSW-1:0] cs   [MAX_SHIFT];
    logic [CSW-1:0] r_cs [MAX_SHIFT][WINDOW];

    always_comb begin
        for (int d = 0; d < MAX_SHIFT; d++) begin
            cs[d] = '0;
            for (int k = 0; k < WINDOW; k++) begin
                cs[d] = cs[d] + CSW'((r_lc[k] > r_rh[d][k]) ? r_lc[k] - r_rh[d][k]
                                                           : r_rh[d][k] - r_lc[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v[1] && adv) begin
            for (int d = 0; d < MAX_SHIFT; d++) begin
                r_cs[d][0] <= cs[d];
                for (int j = 1; j < WINDOW; j++) begin
                    r_cs[d][j] <= r_cs[d][j-1];
                end
            end
        end
    end

    // Window sums and the registered minimum tree; lanes beyond the shift cap read as
    // all ones so that any real sum beats them, and the lower lane wins ties.
    logic [SW-1:0] ws      [MAX_SHIFT];
    logic [SW-1:0] r_tsad  [LV+1][P];
    logic [DW-1:0] r_tidx  [LV+1][P];

    always_comb begin
        for (int d = 0; d < MAX_SHIFT; d++) begin
            ws[d] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                ws[d] = ws[d] + SW'(r_cs[d][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < P; i++) begin
                r_tidx[0][i] <= DW'(i);
                if (i < MAX_SHIFT && DW'(i) <= r_mdmax[2]) begin
                    r_tsad[0][i] <= ws[i];
                end else begin
                    r_tsad[0][i] <= '1;
                end
            end
            for (int l = 0; l < LV; l++) begin
                for (int i = 0; i < P; i++) begin
                    if (i < (P >> (l + 1))) begin
                        if (r_tsad[l][2*i] <= r_tsad[l][2*i+1]) begin
                            r_tsad[l+1][i] <= r_tsad[l][2*i];
                            r_tidx[l+1][i] <= r_tidx[l][2*i];
                        end else begin
                            r_tsad[l+1][i] <= r_tsad[l][2*i+1];
                            r_tidx[l+1][i] <= r_tidx[l][2*i+1];
                        end
                    end else begin
                        r_tsad[l+1][i] <= '1;
                        r_tidx[l+1][i] <= '0;
                    end
                end
            end
        end
    end

    logic [CW-1:0] out_col;
    assign out_col = r_mcol[NS-1] - CW'(HALF);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.row           <= r_mrow[NS-1] - 12'(HALF);
            r_out.col           <= 10'(out_col);
            r_out.disparity     <= 6'(r_tidx[LV][0]);
            r_out.last_of_frame <= r_mlast[NS-1];
        end
    end

    // A forwarded line word only ever belongs to a pixel in the first stage.
    a_fwd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_v[0])
        else $error("line forwarding flagged without a pixel in stage 0");

    // An accepted pixel always lands in the first stage.
    a_accept_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_v[0])
        else $error("accepted pixel lost before stage 0");

    // Shift zero is always in range, so an emitted center never picks a masked lane.
    a_tree_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && r_memit[NS-1]) |-> (r_tsad[LV][0] != '1))
        else $error("minimum tree returned a masked lane");

    // Emitted centers lie at least half a window from the top and left edges.
    a_center_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && r_memit[NS-1]) |->
            (r_mcol[NS-1] >= CW'(LR) && r_mrow[NS-1] >= 12'(LR)))
        else $error("border center flagged for output");
endmodule
